// ----- rtl/core/mtdl_pkg.sv -----
// Shared types and constants for the multipath tapped delay line core.
// Depends on nothing; every other file of the core but mtdl_ram imports it.
`default_nettype none

package mtdl_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int GAIN_W      = 16;
    localparam int DELAY_W     = 6;
    localparam int OUT_W       = 20;
    localparam int FRAC_W      = 14;
    localparam int PATH_SLOTS  = 4;
    localparam int HIST_DEPTH  = 64;
    localparam int HIST_AW     = $clog2(HIST_DEPTH);
    localparam int PROD_W      = GAIN_W + 1 + SAMPLE_W;
    localparam int SUM_W       = PROD_W + 2;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 4;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN0  = 4'd0,
        REG_GAIN1  = 4'd1,
        REG_GAIN2  = 4'd2,
        REG_GAIN3  = 4'd3,
        REG_DELAY0 = 4'd4,
        REG_DELAY1 = 4'd5,
        REG_DELAY2 = 4'd6,
        REG_DELAY3 = 4'd7
    } cfg_reg_t;

    typedef logic [PATH_SLOTS-1:0][GAIN_W-1:0]  gain_arr_t;
    typedef logic [PATH_SLOTS-1:0][DELAY_W-1:0] delay_arr_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last_item;
        logic [DELAY_W-1:0]         flush_len;
    } item_t;

endpackage

`default_nettype wire

// ----- rtl/core/multipath_tapped_delay_line_core.sv -----
// Path: an accepted input beat passes the queue and the read, product, sum and output registers.
// Throughput: one sample per cycle while the output is not stalled; a final sample holds the back
// end for as many flush beats as its largest delay; the flush sequencer feeds the history RAMs.
// Reset: gains and delays return to their defaults (path 0 at unity) and the history reads empty
// at once through its fill count, so no clearing pass is needed.
`default_nettype none

module multipath_tapped_delay_line_core #(
    parameter int NUM_PATHS = 4,
    parameter int MAX_DELAY = 63
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [3:0]            cfg_index,
    input  wire logic [15:0]           cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic signed [15:0]    sample_in,
    input  wire logic                  final_sample,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic signed [19:0]         faded_sample,
    output logic                       end_of_run
);

    import mtdl_pkg::*;

    gain_arr_t  gain_reg;
    delay_arr_t delay_reg;
    delay_arr_t eff_delay;
    logic       q_full;
    logic       q_push;
    item_t      push_item;
    logic       q_valid;
    logic       q_pop;
    item_t      head_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg  <= {{(PATH_SLOTS-1){GAIN_W'(0)}}, GAIN_W'(16384)};
            delay_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GAIN0:  gain_reg[0]  <= cfg_data[GAIN_W-1:0];
                REG_GAIN1:  gain_reg[1]  <= cfg_data[GAIN_W-1:0];
                REG_GAIN2:  gain_reg[2]  <= cfg_data[GAIN_W-1:0];
                REG_GAIN3:  gain_reg[3]  <= cfg_data[GAIN_W-1:0];
                REG_DELAY0: delay_reg[0] <= cfg_data[DELAY_W-1:0];
                REG_DELAY1: delay_reg[1] <= cfg_data[DELAY_W-1:0];
                REG_DELAY2: delay_reg[2] <= cfg_data[DELAY_W-1:0];
                REG_DELAY3: delay_reg[3] <= cfg_data[DELAY_W-1:0];
                default:    ;
            endcase
        end
    end

    // Delays saturate at the maximum; paths beyond the configured count take no part.
    always_comb
    begin
        for (int p = 0; p < PATH_SLOTS; p++)
        begin
            if (p >= NUM_PATHS)
            begin
                eff_delay[p] = '0;
            end
            else if (delay_reg[p] > DELAY_W'(MAX_DELAY))
            begin
                eff_delay[p] = DELAY_W'(MAX_DELAY);
            end
            else
            begin
                eff_delay[p] = delay_reg[p];
            end
        end
    end

    mtdl_front u_front (
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample_in    (sample_in),
        .final_sample (final_sample),
        .delay        (eff_delay),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_item       (push_item)
    );

    mtdl_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (head_item)
    );

    mtdl_back #(
        .NUM_PATHS (NUM_PATHS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_item       (head_item),
        .q_pop        (q_pop),
        .gain         (gain_reg),
        .delay        (eff_delay),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .faded_sample (faded_sample),
        .end_of_run   (end_of_run)
    );

endmodule

`default_nettype wire

// ----- rtl/core/mtdl_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; used for the sample history copies.
`default_nettype none

module mtdl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/mtdl_front.sv -----
// Front end: takes input beats, works out the tail flush length of a final
// sample and hands the classified item to the queue. Uses mtdl_pkg.
`default_nettype none

module mtdl_front (
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic signed [15:0]               sample_in,
    input  wire logic                             final_sample,
    input  wire mtdl_pkg::delay_arr_t             delay,
    input  wire logic                             q_full,
    output logic                                  q_push,
    output mtdl_pkg::item_t                       q_item
);

    import mtdl_pkg::*;

    logic [DELAY_W-1:0] max_delay;

    // Unused paths arrive with a delay of zero, so they never lengthen the tail.
    always_comb
    begin
        max_delay = '0;
        for (int p = 0; p < PATH_SLOTS; p++)
        begin
            if (delay[p] > max_delay)
            begin
                max_delay = delay[p];
            end
        end
    end

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        q_item.sample    = sample_in;
        q_item.last_item = final_sample;
        q_item.flush_len = final_sample ? max_delay : '0;
    end

endmodule

`default_nettype wire

// ----- rtl/core/mtdl_queue.sv -----
// Short register queue between the front end and the back end.
// Uses mtdl_pkg for the item type and depth.
`default_nettype none

module mtdl_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire mtdl_pkg::item_t push_item,
    output logic                 full,
    input  wire logic            pop,
    output logic                 valid,
    output mtdl_pkg::item_t      head
);

    import mtdl_pkg::*;

    item_t               entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg;
    logic [QUEUE_AW:0]   count_next;
    logic                do_pop;

    assign full   = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign valid  = (count_reg != '0);
    assign head   = entry_reg[rd_ptr_reg];
    assign do_pop = pop && valid;

    always_comb
    begin
        count_next = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/mtdl_back.sv -----
// Back end: flush sequencer, sample history copies (one per path) and the
// multiply-accumulate pipeline up to the output register. Uses mtdl_pkg, mtdl_ram.
`default_nettype none

module mtdl_back #(
    parameter int NUM_PATHS = 4
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  q_valid,
    input  wire mtdl_pkg::item_t       q_item,
    output logic                       q_pop,
    input  wire mtdl_pkg::gain_arr_t   gain,
    input  wire mtdl_pkg::delay_arr_t  delay,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic signed [19:0]         faded_sample,
    output logic                       end_of_run
);

    import mtdl_pkg::*;

    localparam int FILL_W = HIST_AW + 1;

    typedef enum logic {
        ST_STREAM,
        ST_FLUSH
    } state_t;

    state_t               state_reg;
    logic [DELAY_W-1:0]   flush_cnt_reg;
    logic [HIST_AW-1:0]   wr_reg;
    logic [HIST_AW-1:0]   wr_next;
    logic [FILL_W-1:0]    fill_reg;
    logic [FILL_W-1:0]    fill_next;

    logic                 adv;
    logic                 issue;
    logic                 beat_last;
    logic signed [SAMPLE_W-1:0] beat_sample;
    logic [HIST_AW-1:0]   wr_inc;

    logic                 v1_reg, v2_reg, v3_reg, out_valid_reg;
    logic                 l1_reg, l2_reg, l3_reg, end_of_run_reg;

    logic signed [SAMPLE_W-1:0] s1_reg;
    logic [PATH_SLOTS-1:0]      byp_next, byp1_reg;
    logic [PATH_SLOTS-1:0]      ok_next, ok1_reg;
    logic [SAMPLE_W-1:0]        rd_data [PATH_SLOTS];
    logic signed [SAMPLE_W-1:0] operand [PATH_SLOTS];
    logic signed [PROD_W-1:0]   prod_next [PATH_SLOTS];
    logic signed [PROD_W-1:0]   prod_reg [PATH_SLOTS];
    logic signed [SUM_W-1:0]    sum_a_reg, sum_b_reg;
    logic signed [SUM_W-1:0]    total;
    logic signed [OUT_W-1:0]    faded_sample_reg;

    // The whole back pipeline moves as one; the output register decides.
    assign adv   = !out_valid_reg || !out_stall;
    assign issue = adv && ((state_reg == ST_FLUSH) || q_valid);
    assign q_pop = adv && (state_reg == ST_STREAM) && q_valid;

    assign beat_sample = (state_reg == ST_FLUSH) ? '0 : q_item.sample;
    assign beat_last   = (state_reg == ST_FLUSH) ? (flush_cnt_reg == DELAY_W'(1))
                                                 : (q_item.last_item && q_item.flush_len == '0);
    assign wr_inc      = wr_reg + 1'b1;

    // The last beat of a waveform returns the history to empty, so the next
    // sample starts a fresh waveform without a clearing pass.
    always_comb
    begin
        wr_next   = wr_reg;
        fill_next = fill_reg;
        if (issue)
        begin
            if (beat_last)
            begin
                wr_next   = '0;
                fill_next = '0;
            end
            else
            begin
                wr_next = wr_inc;
                if (fill_reg != FILL_W'(HIST_DEPTH))
                begin
                    fill_next = fill_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_STREAM;
            flush_cnt_reg  <= '0;
            wr_reg         <= '0;
            fill_reg       <= '0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            v3_reg         <= 1'b0;
            out_valid_reg  <= 1'b0;
            l1_reg         <= 1'b0;
            l2_reg         <= 1'b0;
            l3_reg         <= 1'b0;
            end_of_run_reg <= 1'b0;
        end
        else
        begin
            wr_reg   <= wr_next;
            fill_reg <= fill_next;
            case (state_reg)
                ST_STREAM:
                begin
                    if (q_pop && q_item.last_item && q_item.flush_len != '0)
                    begin
                        state_reg     <= ST_FLUSH;
                        flush_cnt_reg <= q_item.flush_len;
                    end
                end
                ST_FLUSH:
                begin
                    if (adv)
                    begin
                        flush_cnt_reg <= flush_cnt_reg - 1'b1;
                        if (flush_cnt_reg == DELAY_W'(1))
                        begin
                            state_reg <= ST_STREAM;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_STREAM;
                end
            endcase
            if (adv)
            begin
                v1_reg         <= issue;
                v2_reg         <= v1_reg;
                v3_reg         <= v2_reg;
                out_valid_reg  <= v3_reg;
                l1_reg         <= issue && beat_last;
                l2_reg         <= l1_reg;
                l3_reg         <= l2_reg;
                end_of_run_reg <= l3_reg;
            end
        end
    end

    for (genvar p = 0; p < PATH_SLOTS; p++)
    begin : g_lane
        if (p < NUM_PATHS)
        begin : g_used
            logic [HIST_AW-1:0] raddr;

            assign raddr       = wr_inc - delay[p];
            // A zero delay reads the beat being written, so it bypasses the RAM.
            assign byp_next[p] = (delay[p] == '0);
            assign ok_next[p]  = ({1'b0, delay[p]} <= fill_reg);

            mtdl_ram #(
                .WIDTH (SAMPLE_W),
                .DEPTH (HIST_DEPTH)
            ) u_hist (
                .clk   (clk),
                .we    (issue),
                .waddr (wr_inc),
                .wdata (beat_sample),
                .re    (adv),
                .raddr (raddr),
                .rdata (rd_data[p])
            );
        end
        else
        begin : g_unused
            assign byp_next[p] = 1'b0;
            assign ok_next[p]  = 1'b0;
            assign rd_data[p]  = '0;
        end

        assign operand[p]   = ok1_reg[p] ? (byp1_reg[p] ? s1_reg : $signed(rd_data[p])) : '0;
        assign prod_next[p] = PROD_W'($signed({1'b0, gain[p]}) * operand[p]);
    end

    assign total = sum_a_reg + sum_b_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg   <= beat_sample;
            byp1_reg <= byp_next;
            ok1_reg  <= ok_next;
            for (int p = 0; p < PATH_SLOTS; p++)
            begin
                prod_reg[p] <= prod_next[p];
            end
            sum_a_reg <= SUM_W'(prod_reg[0]) + SUM_W'(prod_reg[1]);
            sum_b_reg <= SUM_W'(prod_reg[2]) + SUM_W'(prod_reg[3]);
            // Arithmetic shift by the fraction width, rounding toward minus infinity.
            faded_sample_reg <= total[FRAC_W+OUT_W-1:FRAC_W];
        end
    end

    assign out_valid    = out_valid_reg;
    assign faded_sample = faded_sample_reg;
    assign end_of_run   = end_of_run_reg;

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (issue && beat_last) |=> (wr_reg == '0 && fill_reg == '0))
        else $error("history not emptied after the last beat of a waveform");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(HIST_DEPTH))
        else $error("fill count beyond history depth");

    a_flush_owns_back: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FLUSH) |-> (flush_cnt_reg != '0 && !q_pop))
        else $error("queue popped or empty count during tail flush");

    a_last_is_issued: assert property (@(posedge clk) disable iff (!rst_n)
        (l1_reg && adv) |-> v1_reg)
        else $error("end-of-run flag on an empty pipeline slot");

endmodule

`default_nettype wire
